### src/rvr_pkg.sv
// rvr_pkg: shared widths, fixed-point constants and the cordic arctangent table
// for the rodrigues vector rotation core; no dependencies
`timescale 1ns / 1ps
package rvr_pkg;

   localparam int CORDIC_ITERS = 20;
   // reduction stage, one stage per iteration, rounding stage
   localparam int CORDIC_LAT   = CORDIC_ITERS + 2;
   localparam int ROT_LAT      = 6;
   localparam int TOTAL_LAT    = CORDIC_LAT + ROT_LAT;

   localparam int ZW = 35;   // angle accumulator, q.30
   localparam int XW = 34;   // cordic x/y, q.30

   localparam logic signed [XW-1:0] CORDIC_K    = 34'sd652032874;
   localparam logic signed [ZW-1:0] PI_Q30      = 35'sd3373259426;
   localparam logic signed [ZW-1:0] HALF_PI_Q30 = 35'sd1686629713;

   typedef logic signed [31:0] q16_type;
   typedef logic signed [15:0] q14_type;

   typedef struct packed {
      q16_type vx;
      q16_type vy;
      q16_type vz;
      q14_type kx;
      q14_type ky;
      q14_type kz;
   } geom_type;

   // arctangent of 2^-i in q2.30
   function automatic logic signed [ZW-1:0] atan_entry(input logic [4:0] i);
      logic signed [ZW-1:0] r;
      case (i)
         5'd0:  r = 35'sd843314857;
         5'd1:  r = 35'sd497837829;
         5'd2:  r = 35'sd263043837;
         5'd3:  r = 35'sd133525159;
         5'd4:  r = 35'sd67021687;
         5'd5:  r = 35'sd33543516;
         5'd6:  r = 35'sd16775851;
         5'd7:  r = 35'sd8388437;
         5'd8:  r = 35'sd4194283;
         5'd9:  r = 35'sd2097149;
         5'd10: r = 35'sd1048576;
         default: r = ZW'(35'sd1 <<< (5'd30 - i));
      endcase
      return r;
   endfunction

endpackage

### src/rvr_cordic.sv
// rvr_cordic: pipelined sine/cosine, one cordic iteration per stage, q1.14 out
// depends on rvr_pkg
`timescale 1ns / 1ps
module rvr_cordic
   import rvr_pkg::*;
(
   input  logic           clock,
   input  logic           en,
   input  logic [15:0]    angle,
   output q14_type        sin_q14,
   output q14_type        cos_q14
);

   logic signed [XW-1:0] x_ff [0:CORDIC_ITERS];
   logic signed [XW-1:0] y_ff [0:CORDIC_ITERS];
   logic signed [ZW-1:0] z_ff [0:CORDIC_ITERS];
   logic                 flip_ff [0:CORDIC_ITERS];
   q14_type              sin_ff, cos_ff;

   logic signed [ZW-1:0] z_in;
   logic                 flip_in;
   logic signed [ZW-1:0] z_raw;

   // range reduction into plus or minus pi/2
   always_comb begin
      z_raw   = ZW'($signed(angle)) <<< 17;
      z_in    = z_raw;
      flip_in = 1'b0;
      if (z_raw > HALF_PI_Q30) begin
         z_in    = z_raw - PI_Q30;
         flip_in = 1'b1;
      end else if (z_raw < -HALF_PI_Q30) begin
         z_in    = z_raw + PI_Q30;
         flip_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         x_ff[0]    <= CORDIC_K;
         y_ff[0]    <= '0;
         z_ff[0]    <= z_in;
         flip_ff[0] <= flip_in;
      end
   end

   // rotation stages
   for (genvar i = 0; i < CORDIC_ITERS; i++) begin : g_iter
      always_ff @(posedge clock) begin
         if (en) begin
            flip_ff[i+1] <= flip_ff[i];
            if (!z_ff[i][ZW-1]) begin
               x_ff[i+1] <= x_ff[i] - (y_ff[i] >>> i);
               y_ff[i+1] <= y_ff[i] + (x_ff[i] >>> i);
               z_ff[i+1] <= z_ff[i] - atan_entry(5'(i));
            end else begin
               x_ff[i+1] <= x_ff[i] + (y_ff[i] >>> i);
               y_ff[i+1] <= y_ff[i] - (x_ff[i] >>> i);
               z_ff[i+1] <= z_ff[i] + atan_entry(5'(i));
            end
         end
      end
   end

   // sign fix, round half up to q1.14, clamp
   logic signed [XW:0] xs, ys, xr, yr;
   logic signed [XW-16:0] xq, yq;
   q14_type sin_in, cos_in;

   always_comb begin
      xs = flip_ff[CORDIC_ITERS] ? -(XW+1)'(x_ff[CORDIC_ITERS]) : (XW+1)'(x_ff[CORDIC_ITERS]);
      ys = flip_ff[CORDIC_ITERS] ? -(XW+1)'(y_ff[CORDIC_ITERS]) : (XW+1)'(y_ff[CORDIC_ITERS]);
      xr = xs + (XW+1)'(32768);
      yr = ys + (XW+1)'(32768);
      xq = xr[XW:16];
      yq = yr[XW:16];
      if (xq > 19'sd16384)       cos_in = 16'sd16384;
      else if (xq < -19'sd16384) cos_in = -16'sd16384;
      else                       cos_in = 16'(xq);
      if (yq > 19'sd16384)       sin_in = 16'sd16384;
      else if (yq < -19'sd16384) sin_in = -16'sd16384;
      else                       sin_in = 16'(yq);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         sin_ff <= sin_in;
         cos_ff <= cos_in;
      end
   end

   assign sin_q14 = sin_ff;
   assign cos_q14 = cos_ff;

endmodule

### src/rvr_rotate.sv
// rvr_rotate: six-stage rodrigues datapath, cross/dot products, scaling, sum and saturate
// depends on rvr_pkg
`timescale 1ns / 1ps
module rvr_rotate
   import rvr_pkg::*;
(
   input  logic     clock,
   input  logic     en,
   input  geom_type geom,
   input  q14_type  sin_q14,
   input  q14_type  cos_q14,
   output q16_type  out_x,
   output q16_type  out_y,
   output q16_type  out_z,
   output logic     overflow
);

   // stage 1: all element products
   logic signed [47:0] p_ff [0:8];   // ky*vz, kz*vy, kz*vx, kx*vz, kx*vy, ky*vx, kx*vx, ky*vy, kz*vz
   logic signed [47:0] t1a_ff [0:2];
   q14_type s1_ff, c1_ff;
   q14_type k1_ff [0:2];

   always_ff @(posedge clock) begin
      if (en) begin
         p_ff[0] <= 48'(geom.ky) * 48'(geom.vz);
         p_ff[1] <= 48'(geom.kz) * 48'(geom.vy);
         p_ff[2] <= 48'(geom.kz) * 48'(geom.vx);
         p_ff[3] <= 48'(geom.kx) * 48'(geom.vz);
         p_ff[4] <= 48'(geom.kx) * 48'(geom.vy);
         p_ff[5] <= 48'(geom.ky) * 48'(geom.vx);
         p_ff[6] <= 48'(geom.kx) * 48'(geom.vx);
         p_ff[7] <= 48'(geom.ky) * 48'(geom.vy);
         p_ff[8] <= 48'(geom.kz) * 48'(geom.vz);
         t1a_ff[0] <= 48'(cos_q14) * 48'(geom.vx);
         t1a_ff[1] <= 48'(cos_q14) * 48'(geom.vy);
         t1a_ff[2] <= 48'(cos_q14) * 48'(geom.vz);
         s1_ff <= sin_q14;
         c1_ff <= cos_q14;
         k1_ff[0] <= geom.kx;
         k1_ff[1] <= geom.ky;
         k1_ff[2] <= geom.kz;
      end
   end

   // stage 2: cross product and rounded dot product
   logic signed [48:0] cr2_ff [0:2];
   logic signed [35:0] d2_ff;
   logic signed [47:0] t1b_ff [0:2];
   q14_type s2_ff, c2_ff;
   q14_type k2_ff [0:2];
   logic signed [50:0] dot_w;

   assign dot_w = 51'(p_ff[6]) + 51'(p_ff[7]) + 51'(p_ff[8]) + 51'sd8192;

   always_ff @(posedge clock) begin
      if (en) begin
         cr2_ff[0] <= 49'(p_ff[0]) - 49'(p_ff[1]);
         cr2_ff[1] <= 49'(p_ff[2]) - 49'(p_ff[3]);
         cr2_ff[2] <= 49'(p_ff[4]) - 49'(p_ff[5]);
         d2_ff     <= dot_w[49:14];
         t1b_ff    <= t1a_ff;
         s2_ff     <= s1_ff;
         c2_ff     <= c1_ff;
         k2_ff     <= k1_ff;
      end
   end

   // stage 3: sine term products and the (1 - cos) scale of the dot
   logic signed [64:0] sc3_ff [0:2];
   logic signed [52:0] mr3_ff;
   logic signed [47:0] t1c_ff [0:2];
   q14_type k3_ff [0:2];
   logic signed [16:0] omc;

   assign omc = 17'sd16384 - 17'(c2_ff);

   always_ff @(posedge clock) begin
      if (en) begin
         for (int j = 0; j < 3; j++) begin
            sc3_ff[j] <= 65'(s2_ff) * 65'(cr2_ff[j]);
         end
         mr3_ff <= 53'(d2_ff) * 53'(omc);
         t1c_ff <= t1b_ff;
         k3_ff  <= k2_ff;
      end
   end

   // stage 4: round the sine terms and m
   logic signed [50:0] t2_ff [0:2];
   logic signed [38:0] m4_ff;
   logic signed [47:0] t1d_ff [0:2];
   q14_type k4_ff [0:2];
   logic signed [65:0] scr [0:2];
   logic signed [53:0] mrr;

   always_comb begin
      for (int j = 0; j < 3; j++) begin
         scr[j] = 66'(sc3_ff[j]) + 66'sd8192;
      end
      mrr = 54'(mr3_ff) + 54'sd8192;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int j = 0; j < 3; j++) begin
            t2_ff[j] <= scr[j][64:14];
         end
         m4_ff  <= mrr[52:14];
         t1d_ff <= t1c_ff;
         k4_ff  <= k3_ff;
      end
   end

   // stage 5: axis term and component sums
   logic signed [56:0] sum5_ff [0:2];

   always_ff @(posedge clock) begin
      if (en) begin
         for (int j = 0; j < 3; j++) begin
            sum5_ff[j] <= 57'(t1d_ff[j]) + 57'(t2_ff[j]) + 57'(55'(k4_ff[j]) * 55'(m4_ff));
         end
      end
   end

   // stage 6: round to q16.16 and saturate
   logic signed [57:0] rr [0:2];
   logic signed [43:0] rq [0:2];
   q16_type res_in [0:2];
   logic [2:0] sat;
   q16_type res_ff [0:2];
   logic ovf_ff;

   always_comb begin
      for (int j = 0; j < 3; j++) begin
         rr[j] = 58'(sum5_ff[j]) + 58'sd8192;
         rq[j] = rr[j][57:14];
         sat[j] = 1'b0;
         res_in[j] = 32'(rq[j]);
         if (rq[j] > 44'sd2147483647) begin
            res_in[j] = 32'sh7fffffff;
            sat[j]    = 1'b1;
         end else if (rq[j] < -44'sd2147483648) begin
            res_in[j] = 32'sh80000000;
            sat[j]    = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         res_ff <= res_in;
         ovf_ff <= |sat;
      end
   end

   assign out_x    = res_ff[0];
   assign out_y    = res_ff[1];
   assign out_z    = res_ff[2];
   assign overflow = ovf_ff;

endmodule

### src/rodrigues_vector_rotation_core.sv
// rodrigues_vector_rotation_core: top level, stream handshake, valid chain and geometry delay
// depends on rvr_pkg, rvr_cordic, rvr_rotate
// each input beat passes the cordic pipe, then the rotation datapath, to become its result beat
// throughput: one beat per cycle; the whole pipe holds while a result waits on rsp_tready
// the pipe advances while the last stage is empty or being taken
// reset: synchronous active high, clears the valid chain only; no state between items
`timescale 1ns / 1ps
module rodrigues_vector_rotation_core
   import rvr_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_tvalid,
   output logic          req_tready,
   input  logic [159:0]  req_tdata,   // vec_x, vec_y, vec_z, axis_x, axis_y, axis_z, rot_angle
   output logic          rsp_tvalid,
   input  logic          rsp_tready,
   output logic [95:0]   rsp_tdata,   // out_x, out_y, out_z
   output logic          rsp_tuser    // overflow
);

   logic en;
   logic [TOTAL_LAT-1:0] vld_ff;
   geom_type geom_in;
   geom_type dly_ff [0:CORDIC_LAT-1];
   q14_type sin_q14, cos_q14;
   q16_type ox, oy, oz;
   logic ovf;

   assign en         = !vld_ff[TOTAL_LAT-1] || rsp_tready;
   assign req_tready = en;

   // valid bits travel with the data
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= {vld_ff[TOTAL_LAT-2:0], req_tvalid};
      end
   end

   assign geom_in.vx = req_tdata[31:0];
   assign geom_in.vy = req_tdata[63:32];
   assign geom_in.vz = req_tdata[95:64];
   assign geom_in.kx = req_tdata[111:96];
   assign geom_in.ky = req_tdata[127:112];
   assign geom_in.kz = req_tdata[143:128];

   // geometry delay matching the cordic depth
   always_ff @(posedge clock) begin
      if (en) begin
         dly_ff[0] <= geom_in;
         for (int j = 1; j < CORDIC_LAT; j++) begin
            dly_ff[j] <= dly_ff[j-1];
         end
      end
   end

   rvr_cordic u_cordic (
      .clock   (clock),
      .en      (en),
      .angle   (req_tdata[159:144]),
      .sin_q14 (sin_q14),
      .cos_q14 (cos_q14)
   );

   rvr_rotate u_rotate (
      .clock    (clock),
      .en       (en),
      .geom     (dly_ff[CORDIC_LAT-1]),
      .sin_q14  (sin_q14),
      .cos_q14  (cos_q14),
      .out_x    (ox),
      .out_y    (oy),
      .out_z    (oz),
      .overflow (ovf)
   );

   assign rsp_tvalid = vld_ff[TOTAL_LAT-1];
   assign rsp_tdata  = {oz, oy, ox};
   assign rsp_tuser  = ovf;

endmodule
